FILE: rtl/vad_pkg.sv
// ----------------------------------------------------------------------------
// vad_pkg
// Shared types, widths and constants for the vector angle core.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int unsigned COORD_BITS      = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 8;
  localparam int unsigned ANGLE_BITS      = 16;

  // integer datapath widths
  localparam int unsigned PROD_W = 2 * COORD_BITS;
  localparam int unsigned DOT_W  = PROD_W + 2;
  localparam int unsigned DMAG_W = PROD_W + 1;
  localparam int unsigned CR_W   = PROD_W;
  localparam int unsigned CRX_W  = CR_W + 1;
  localparam int unsigned SQ_W   = 2 * CR_W;
  localparam int unsigned SUM_W  = SQ_W + 2;
  localparam int unsigned BL_W   = $clog2(DMAG_W + 1);

  // normalize and square root
  localparam int unsigned RAD_W      = 128;
  localparam int unsigned ROOT_W     = 64;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned NORM_STEPS = $clog2(ROOT_W);
  localparam int unsigned K_W        = NORM_STEPS;
  localparam int unsigned XW_W       = DMAG_W + ROOT_W - 1;
  localparam int unsigned LEN_W      = $clog2(XW_W + 1);

  // rotation datapath, radians in q60
  localparam int unsigned FRAC_Q    = 60;
  localparam int unsigned ROT_STEPS = 60;
  localparam int unsigned CW        = 64;
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60   = 64'd1 << FRAC_Q;

  // radians to degrees
  localparam int unsigned THETA_W = 62;
  localparam int unsigned SCALE   = 180 << ANGLE_FRAC_BITS;
  localparam int unsigned SCALE_W = $clog2(SCALE + 1);
  localparam int unsigned NUM_W   = THETA_W + SCALE_W + 1;
  localparam logic [ANGLE_BITS-1:0] ANGLE_180 = ANGLE_BITS'(SCALE);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] deg_fx;
    logic                  zero_vector;
  } out_t;

  // flags that ride along with each item
  typedef struct packed {
    logic zero;
    logic szero;
    logic dneg;
  } side_t;

  // shift and subtract quotient, elaboration only
  function automatic logic [63:0] div_small(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q60 from the truncated power series, elaboration only
  function automatic logic [63:0] atan_pow2(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned sh;
    acc = '0;
    if (i == 0) begin
      return PI_Q60 >> 2;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 61) begin
        term = div_small(ONE_Q60 >> sh, 64'(2 * k + 1));
        acc  = k[0] ? acc - term : acc + term;
      end
    end
    return acc;
  endfunction

endpackage

FILE: rtl/vector_angle_degrees_core.sv
// ----------------------------------------------------------------------------
// vector_angle_degrees_core
// A result passes the product, normalize, 64-stage square root, align,
// 60-stage rotation, fold and scale, and division stages in that order.
// Throughput: one beat per cycle unless the two-entry output buffer is full,
// which halts every stage. Reset clears all valid bits; data keeps junk.
// ----------------------------------------------------------------------------
module vector_angle_degrees_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vad_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vad_pkg::out_t  out_data_o
);

  localparam int unsigned PROD_W = vad_pkg::PROD_W;
  localparam int unsigned DOT_W  = vad_pkg::DOT_W;
  localparam int unsigned DMAG_W = vad_pkg::DMAG_W;
  localparam int unsigned CR_W   = vad_pkg::CR_W;
  localparam int unsigned CRX_W  = vad_pkg::CRX_W;
  localparam int unsigned SQ_W   = vad_pkg::SQ_W;
  localparam int unsigned SUM_W  = vad_pkg::SUM_W;
  localparam int unsigned BL_W   = vad_pkg::BL_W;
  localparam int unsigned RAD_W  = vad_pkg::RAD_W;
  localparam int unsigned ROOT_W = vad_pkg::ROOT_W;
  localparam int unsigned REM_W  = vad_pkg::REM_W;
  localparam int unsigned NSTEP  = vad_pkg::NORM_STEPS;
  localparam int unsigned K_W    = vad_pkg::K_W;
  localparam int unsigned XW_W   = vad_pkg::XW_W;
  localparam int unsigned LEN_W  = vad_pkg::LEN_W;
  localparam int unsigned ROT    = vad_pkg::ROT_STEPS;
  localparam int unsigned CW     = vad_pkg::CW;
  localparam int unsigned TH_W   = vad_pkg::THETA_W;
  localparam int unsigned NUM_W  = vad_pkg::NUM_W;
  localparam int unsigned ANG_W  = vad_pkg::ANGLE_BITS;
  localparam int unsigned NSTG   = 4 + NSTEP + ROOT_W + 1 + ROT + 3 + ANG_W;

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  logic              en;
  logic              skid_v_q;
  logic              out_valid_q;
  logic [NSTG-1:0]   vld_q;
  vad_pkg::out_t     out_q, skid_q, res;
  logic              push, pop;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: nine products and the zero check
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] pxx_q, pyy_q, pzz_q;
  logic signed [PROD_W-1:0] pyz_q, pzy_q, pzx_q, pxz_q, pxy_q, pyx_q;
  logic                     zero1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q   <= in_data_i.a_x * in_data_i.b_x;
      pyy_q   <= in_data_i.a_y * in_data_i.b_y;
      pzz_q   <= in_data_i.a_z * in_data_i.b_z;
      pyz_q   <= in_data_i.a_y * in_data_i.b_z;
      pzy_q   <= in_data_i.a_z * in_data_i.b_y;
      pzx_q   <= in_data_i.a_z * in_data_i.b_x;
      pxz_q   <= in_data_i.a_x * in_data_i.b_z;
      pxy_q   <= in_data_i.a_x * in_data_i.b_y;
      pyx_q   <= in_data_i.a_y * in_data_i.b_x;
      zero1_q <= (in_data_i.a_x == '0 && in_data_i.a_y == '0 && in_data_i.a_z == '0) ||
                 (in_data_i.b_x == '0 && in_data_i.b_y == '0 && in_data_i.b_z == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: dot product magnitude and sign, cross product magnitudes
  // --------------------------------------------------------------------------
  logic signed [DOT_W-1:0] dot_s;
  logic signed [CRX_W-1:0] fx, fy, fz;
  logic [DMAG_W-1:0]       dmag2_q;
  logic                    dneg2_q, zero2_q;
  logic [CR_W-1:0]         cmx_q, cmy_q, cmz_q;

  always_comb begin
    dot_s = DOT_W'(pxx_q) + DOT_W'(pyy_q) + DOT_W'(pzz_q);
    fx    = CRX_W'(pyz_q) - CRX_W'(pzy_q);
    fy    = CRX_W'(pzx_q) - CRX_W'(pxz_q);
    fz    = CRX_W'(pxy_q) - CRX_W'(pyx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg2_q <= dot_s[DOT_W-1];
      dmag2_q <= DMAG_W'(dot_s[DOT_W-1] ? -dot_s : dot_s);
      cmx_q   <= CR_W'(fx[CRX_W-1] ? -fx : fx);
      cmy_q   <= CR_W'(fy[CRX_W-1] ? -fy : fy);
      cmz_q   <= CR_W'(fz[CRX_W-1] ? -fz : fz);
      zero2_q <= zero1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: squares of the cross components, bit length of the dot
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [DMAG_W-1:0] dmag3_q;
  logic [BL_W-1:0]   bl_d, bl3_q;
  logic              dneg3_q, zero3_q;

  always_comb begin
    bl_d = '0;
    for (int i = 0; i < int'(DMAG_W); i++) begin
      if (dmag2_q[i]) bl_d = BL_W'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q   <= SQ_W'(cmx_q) * SQ_W'(cmx_q);
      sqy_q   <= SQ_W'(cmy_q) * SQ_W'(cmy_q);
      sqz_q   <= SQ_W'(cmz_q) * SQ_W'(cmz_q);
      dmag3_q <= dmag2_q;
      bl3_q   <= bl_d;
      dneg3_q <= dneg2_q;
      zero3_q <= zero2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: squared cross magnitude
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  sum4_q;
  logic [DMAG_W-1:0] dmag4_q;
  logic [BL_W-1:0]   bl4_q;
  logic              dneg4_q, zero4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum4_q  <= SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
      dmag4_q <= dmag3_q;
      bl4_q   <= bl3_q;
      dneg4_q <= dneg3_q;
      zero4_q <= zero3_q;
    end
  end

  // --------------------------------------------------------------------------
  // normalize: shift the radicand by pairs until its top two bits are not zero,
  // the dot magnitude follows by half the distance
  // --------------------------------------------------------------------------
  logic [RAD_W-1:0]    nrad_q [NSTEP];
  logic [XW_W-1:0]     nxw_q  [NSTEP];
  logic [K_W-1:0]      nk_q   [NSTEP];
  logic [BL_W-1:0]     nbl_q  [NSTEP];
  vad_pkg::side_t      nsd_q  [NSTEP];

  for (genvar t = 0; t < NSTEP; t++) begin : g_norm
    localparam int unsigned SH = 1 << (NSTEP - 1 - t);
    logic [RAD_W-1:0] rin;
    logic [XW_W-1:0]  xin;
    logic [K_W-1:0]   kin;
    logic [BL_W-1:0]  blin;
    vad_pkg::side_t   sdin;
    logic             hit;

    if (t == 0) begin : g_src
      assign rin  = RAD_W'(sum4_q);
      assign xin  = XW_W'(dmag4_q);
      assign kin  = '0;
      assign blin = bl4_q;
      assign sdin = '{zero: zero4_q, szero: (sum4_q == '0), dneg: dneg4_q};
    end else begin : g_src
      assign rin  = nrad_q[t-1];
      assign xin  = nxw_q[t-1];
      assign kin  = nk_q[t-1];
      assign blin = nbl_q[t-1];
      assign sdin = nsd_q[t-1];
    end

    assign hit = (rin[RAD_W-1 -: 2*SH] == '0);

    always_ff @(posedge clk_i) begin
      if (en) begin
        nrad_q[t] <= hit ? rin << (2 * SH) : rin;
        nxw_q[t]  <= hit ? xin << SH : xin;
        nk_q[t]   <= hit ? kin + K_W'(SH) : kin;
        nbl_q[t]  <= blin;
        nsd_q[t]  <= sdin;
      end
    end
  end

  // --------------------------------------------------------------------------
  // square root, one result bit per stage
  // --------------------------------------------------------------------------
  logic [REM_W-1:0]  srem_q  [ROOT_W];
  logic [ROOT_W-1:0] sroot_q [ROOT_W];
  logic [RAD_W-1:0]  srad_q  [ROOT_W];
  logic [XW_W-1:0]   sxw_q   [ROOT_W];
  logic [LEN_W-1:0]  slen_q  [ROOT_W];
  vad_pkg::side_t    ssd_q   [ROOT_W];

  for (genvar b = 0; b < ROOT_W; b++) begin : g_sqrt
    logic [REM_W-1:0]  rin, rem2, trial;
    logic [ROOT_W-1:0] rootin;
    logic [RAD_W-1:0]  radin;
    logic [XW_W-1:0]   xin;
    logic [LEN_W-1:0]  lin;
    vad_pkg::side_t    sdin;
    logic              ge;

    if (b == 0) begin : g_src
      assign rin    = '0;
      assign rootin = '0;
      assign radin  = nrad_q[NSTEP-1];
      assign xin    = nxw_q[NSTEP-1];
      // bit length of the shifted dot magnitude
      assign lin    = LEN_W'(nbl_q[NSTEP-1]) + LEN_W'(nk_q[NSTEP-1]);
      assign sdin   = nsd_q[NSTEP-1];
    end else begin : g_src
      assign rin    = srem_q[b-1];
      assign rootin = sroot_q[b-1];
      assign radin  = srad_q[b-1];
      assign xin    = sxw_q[b-1];
      assign lin    = slen_q[b-1];
      assign sdin   = ssd_q[b-1];
    end

    assign rem2  = {rin[REM_W-3:0], radin[RAD_W-1 -: 2]};
    assign trial = REM_W'({rootin, 2'b01});
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[b]  <= ge ? rem2 - trial : rem2;
        sroot_q[b] <= {rootin[ROOT_W-2:0], ge};
        srad_q[b]  <= radin << 2;
        sxw_q[b]   <= xin;
        slen_q[b]  <= lin;
        ssd_q[b]   <= sdin;
      end
    end
  end

  // --------------------------------------------------------------------------
  // align both legs below 2^60
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]     len_d, rsh_d;
  logic signed [CW-1:0] shx_q, shy_q;
  vad_pkg::side_t       shsd_q;

  always_comb begin
    // a nonzero root has its top bit set, so it sets the floor of the length
    len_d = (slen_q[ROOT_W-1] > LEN_W'(ROOT_W)) ? slen_q[ROOT_W-1] : LEN_W'(ROOT_W);
    rsh_d = len_d - LEN_W'(vad_pkg::FRAC_Q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      shx_q  <= CW'(sxw_q[ROOT_W-1] >> rsh_d);
      shy_q  <= CW'(sroot_q[ROOT_W-1] >> rsh_d);
      shsd_q <= ssd_q[ROOT_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // circular vectoring rotations
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] rx_q [ROT];
  logic signed [CW-1:0] ry_q [ROT];
  logic signed [CW-1:0] rz_q [ROT];
  vad_pkg::side_t       rsd_q [ROT];

  for (genvar i = 0; i < ROT; i++) begin : g_rot
    localparam logic [CW-1:0] ATAN_I = CW'(vad_pkg::atan_pow2(i));
    localparam logic [CW-1:0] BIAS_I = (CW'(1) << i) - CW'(1);
    logic signed [CW-1:0] xin, yin, zin, ybias, dx, dy;
    vad_pkg::side_t       sdin;
    logic                 neg;

    if (i == 0) begin : g_src
      assign xin  = shx_q;
      assign yin  = shy_q;
      assign zin  = '0;
      assign sdin = shsd_q;
    end else begin : g_src
      assign xin  = rx_q[i-1];
      assign yin  = ry_q[i-1];
      assign zin  = rz_q[i-1];
      assign sdin = rsd_q[i-1];
    end

    assign neg = yin[CW-1];
    // shift of y rounds toward zero
    assign ybias = yin + (neg ? BIAS_I : CW'(0));
    assign dx    = ybias >>> i;
    assign dy    = xin >>> i;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[i]  <= neg ? xin - dx : xin + dx;
        ry_q[i]  <= neg ? yin + dy : yin - dy;
        rz_q[i]  <= neg ? zin - ATAN_I : zin + ATAN_I;
        rsd_q[i] <= sdin;
      end
    end
  end

  // --------------------------------------------------------------------------
  // fold into [0, pi], scale to degrees, add half of pi for rounding
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] th_d;
  logic [TH_W-1:0]      th_clamp;
  logic [TH_W-1:0]      theta_q;
  logic [NUM_W-1:0]     prod_q, num_q;
  vad_pkg::side_t       thsd_q, msd_q, asd_q;

  always_comb begin
    th_d = rsd_q[ROT-1].dneg ? $signed(vad_pkg::PI_Q60) - rz_q[ROT-1] : rz_q[ROT-1];
    if (th_d < 0) begin
      th_clamp = '0;
    end else if ($unsigned(th_d) > vad_pkg::PI_Q60) begin
      th_clamp = TH_W'(vad_pkg::PI_Q60);
    end else begin
      th_clamp = TH_W'(th_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      theta_q <= th_clamp;
      thsd_q  <= rsd_q[ROT-1];
      prod_q  <= NUM_W'(theta_q) * NUM_W'(vad_pkg::SCALE);
      msd_q   <= thsd_q;
      num_q   <= prod_q + NUM_W'(vad_pkg::PI_Q60 >> 1);
      asd_q   <= msd_q;
    end
  end

  // --------------------------------------------------------------------------
  // restoring division by pi, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] drem_q [ANG_W];
  logic [ANG_W-1:0] dq_q   [ANG_W];
  vad_pkg::side_t   dsd_q  [ANG_W];

  for (genvar t = 0; t < ANG_W; t++) begin : g_div
    localparam logic [NUM_W-1:0] DV = NUM_W'(vad_pkg::PI_Q60) << (ANG_W - 1 - t);
    logic [NUM_W-1:0] rin;
    logic [ANG_W-1:0] qin;
    vad_pkg::side_t   sdin;
    logic             ge;

    if (t == 0) begin : g_src
      assign rin  = num_q;
      assign qin  = '0;
      assign sdin = asd_q;
    end else begin : g_src
      assign rin  = drem_q[t-1];
      assign qin  = dq_q[t-1];
      assign sdin = dsd_q[t-1];
    end

    assign ge = (rin >= DV);

    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[t] <= ge ? rin - DV : rin;
        dq_q[t]   <= {qin[ANG_W-2:0], ge};
        dsd_q[t]  <= sdin;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result select and output buffer
  // --------------------------------------------------------------------------
  always_comb begin
    res.zero_vector = dsd_q[ANG_W-1].zero;
    if (dsd_q[ANG_W-1].zero) begin
      res.deg_fx = '0;
    end else if (dsd_q[ANG_W-1].szero) begin
      // parallel vectors
      res.deg_fx = dsd_q[ANG_W-1].dneg ? vad_pkg::ANGLE_180 : '0;
    end else begin
      res.deg_fx = dq_q[ANG_W-1];
    end
  end

  assign push = vld_q[NSTG-1] & en;
  assign pop  = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid entry held without a presented result");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.deg_fx <= vad_pkg::ANGLE_180))
    else $error("angle above 180 degrees");

  a_zero_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_vector) |-> (out_data_o.deg_fx == '0))
    else $error("zero vector with nonzero angle");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_ready_i) |=> (skid_v_q && $stable(out_q)))
    else $error("buffered results moved while stalled");

endmodule
